// File: sv/sliding_window_packet_rate_meter_core_assert.svh
// Assertion helpers shared by the checker files of this block.
// Both macros expect signals named clk and rst_n in the calling scope.
`ifndef SLIDING_WINDOW_PACKET_RATE_METER_CORE_ASSERT_SVH
`define SLIDING_WINDOW_PACKET_RATE_METER_CORE_ASSERT_SVH

// Property that must hold at every clock edge outside reset.
`define SWPRM_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("swprm checker: property violated");

// Consequent must hold in the cycle after the antecedent.
`define SWPRM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("swprm checker: sequence violated");

`endif

// File: sv/swprm_pkg.sv
package swprm_pkg;

    localparam int MAX_ARRIVALS_DEF = 64;

    localparam int TIME_W = 48;
    localparam int CFG_W  = 24;
    localparam int RATE_W = 36;
    localparam int HELD_W = 7;
    localparam int CMD_W  = 2;
    localparam int IDX_W  = 1;

    // Item commands. The unused code behaves as a query.
    localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_RECORD = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_SPARE  = 2'd3;

    // Configuration register indexes.
    localparam logic [IDX_W-1:0] REG_WINDOW = 1'd0;
    localparam logic [IDX_W-1:0] REG_GAP    = 1'd1;

    localparam logic [CFG_W-1:0] WINDOW_RESET = 24'd1000000;
    localparam logic [CFG_W-1:0] GAP_RESET    = 24'd2000000;

    // One second in microseconds, scaled by 2^8 for the Q.8 result.
    localparam int USEC_Q8_W = 28;
    localparam logic [USEC_Q8_W-1:0] USEC_Q8 = 28'd256000000;

    localparam logic [RATE_W-1:0] RATE_MAX = '1;

    typedef struct packed {
        logic latch;
        logic pre;
        logic ins_rd;
        logic ins_move;
        logic ins_put;
        logic pr_drop;
        logic pr_keep;
        logic rate_setup;
        logic div_step;
        logic load_out;
    } ctl_cmd_t;

    typedef struct packed {
        logic is_rec;
        logic ins_zero;
        logic rd_gt;
        logic pr_old;
        logic div_last;
    } ctl_sts_t;

endpackage

// File: sv/swprm_if.sv
interface swprm_in_if;
    logic                            valid;
    logic                            ready;
    logic [swprm_pkg::CMD_W-1:0]     cmd;
    logic [swprm_pkg::TIME_W-1:0]    time_us;

    modport source (output valid, output cmd, output time_us, input ready);
    modport sink (input valid, input cmd, input time_us, output ready);
endinterface

interface swprm_out_if;
    logic                            valid;
    logic                            ready;
    logic [swprm_pkg::RATE_W-1:0]    rate_q8;
    logic [swprm_pkg::HELD_W-1:0]    arrivals_held;
    logic                            dropped_full;

    modport source (output valid, output rate_q8, output arrivals_held,
                    output dropped_full, input ready);
    modport sink (input valid, input rate_q8, input arrivals_held,
                  input dropped_full, output ready);
endinterface

// File: sv/swprm_ram.sv
module swprm_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: sv/swprm_ctrl.sv
module swprm_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  swprm_pkg::ctl_sts_t  sts,
    output swprm_pkg::ctl_cmd_t  ctl
);

    import swprm_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PRE,
        S_INS_CHK,
        S_INS_CMP,
        S_PR_RD,
        S_PR_CMP,
        S_RATE,
        S_DIV,
        S_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        ctl        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ctl.latch  = 1'b1;
                    state_next = S_PRE;
                end
            end
            S_PRE:
            begin
                ctl.pre    = 1'b1;
                state_next = sts.is_rec ? S_INS_CHK : S_RATE;
            end
            S_INS_CHK:
            begin
                if (sts.ins_zero)
                begin
                    ctl.ins_put = 1'b1;
                    state_next  = S_PR_RD;
                end
                else
                begin
                    ctl.ins_rd = 1'b1;
                    state_next = S_INS_CMP;
                end
            end
            S_INS_CMP:
            begin
                if (sts.rd_gt)
                begin
                    ctl.ins_move = 1'b1;
                    state_next   = S_INS_CHK;
                end
                else
                begin
                    ctl.ins_put = 1'b1;
                    state_next  = S_PR_RD;
                end
            end
            S_PR_RD:
            begin
                state_next = S_PR_CMP;
            end
            S_PR_CMP:
            begin
                if (sts.pr_old)
                begin
                    ctl.pr_drop = 1'b1;
                    state_next  = S_PR_RD;
                end
                else
                begin
                    ctl.pr_keep = 1'b1;
                    state_next  = S_RATE;
                end
            end
            S_RATE:
            begin
                ctl.rate_setup = 1'b1;
                state_next     = S_DIV;
            end
            S_DIV:
            begin
                ctl.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    ctl.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (ctl.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// File: sv/swprm_dp.sv
module swprm_dp #(
    parameter int MAX_ARRIVALS = swprm_pkg::MAX_ARRIVALS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  swprm_pkg::ctl_cmd_t           ctl,
    output swprm_pkg::ctl_sts_t           sts,
    input  logic [swprm_pkg::CMD_W-1:0]   item_cmd,
    input  logic [swprm_pkg::TIME_W-1:0]  item_time,
    input  logic                          cfg_we,
    input  logic [swprm_pkg::IDX_W-1:0]   cfg_index,
    input  logic [swprm_pkg::CFG_W-1:0]   cfg_data,
    output logic [swprm_pkg::RATE_W-1:0]  rate_q8,
    output logic [swprm_pkg::HELD_W-1:0]  arrivals_held,
    output logic                          dropped_full
);

    import swprm_pkg::*;

    localparam int PTR_W  = (MAX_ARRIVALS > 1) ? $clog2(MAX_ARRIVALS) : 1;
    localparam int CNT_W  = $clog2(MAX_ARRIVALS + 1);
    localparam int SUM_W  = PTR_W + 2;
    localparam int NUM_W  = CNT_W + USEC_Q8_W;
    localparam int DCNT_W = $clog2(NUM_W);
    localparam int SAT_W  = (NUM_W > RATE_W) ? NUM_W : RATE_W;

    logic [CMD_W-1:0]  op_reg;
    logic [TIME_W-1:0] t_reg;
    logic [CFG_W-1:0]  window_reg, gap_reg;
    logic [PTR_W-1:0]  head_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  ins_reg;
    logic [TIME_W-1:0] newest_reg, oldest_reg, span_reg;
    logic              dropped_reg, zero_reg;
    logic [NUM_W-1:0]  quo_reg;
    logic [TIME_W-1:0] rem_reg;
    logic [DCNT_W-1:0] div_cnt_reg;
    logic [RATE_W-1:0] rate_out_reg;
    logic [HELD_W-1:0] held_out_reg;
    logic              drop_out_reg;

    logic              ram_we;
    logic [PTR_W-1:0]  ram_waddr, ram_raddr;
    logic [TIME_W-1:0] ram_wdata, rd_data;

    logic              gap_hit, evict;
    logic [CNT_W-1:0]  cnt_after_gap;
    logic [CNT_W-1:0]  cnt_m1;
    logic [TIME_W-1:0] since_newest;
    logic              rate_zero;
    logic [TIME_W:0]   trial;
    logic              trial_ge;
    logic [SAT_W-1:0]  quo_ext;
    logic [RATE_W-1:0] rate_sat;

    // Circular addressing: logical slot rel counted from the oldest entry.
    function automatic logic [PTR_W-1:0] phys(input logic [PTR_W-1:0] head,
                                              input logic [CNT_W-1:0] rel);
        logic [SUM_W-1:0] s;
        s = SUM_W'(head) + SUM_W'(rel);
        if (s >= SUM_W'(MAX_ARRIVALS))
        begin
            s = s - SUM_W'(MAX_ARRIVALS);
        end
        return s[PTR_W-1:0];
    endfunction

    function automatic logic [PTR_W-1:0] inc_ptr(input logic [PTR_W-1:0] p);
        logic [PTR_W:0] s;
        s = {1'b0, p} + (PTR_W+1)'(1);
        if (s >= (PTR_W+1)'(MAX_ARRIVALS))
        begin
            s = '0;
        end
        return s[PTR_W-1:0];
    endfunction

    swprm_ram #(
        .WIDTH (TIME_W),
        .DEPTH (MAX_ARRIVALS)
    ) u_times (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (rd_data)
    );

    assign ram_raddr = ctl.ins_rd ? phys(head_reg, ins_reg - CNT_W'(1)) : head_reg;
    assign ram_we    = ctl.ins_move | ctl.ins_put;
    assign ram_waddr = phys(head_reg, ins_reg);
    assign ram_wdata = ctl.ins_move ? rd_data : t_reg;

    assign since_newest  = t_reg - newest_reg;
    assign gap_hit       = (count_reg != '0) && (t_reg >= newest_reg)
                           && (since_newest >= TIME_W'(gap_reg));
    assign cnt_after_gap = gap_hit ? '0 : count_reg;
    assign evict         = (cnt_after_gap == CNT_W'(MAX_ARRIVALS));
    assign cnt_m1        = count_reg - CNT_W'(1);

    assign rate_zero = (count_reg < CNT_W'(2)) || (t_reg < newest_reg)
                       || (since_newest >= TIME_W'(gap_reg))
                       || (newest_reg == oldest_reg);

    // One restoring division step per cycle.
    assign trial    = {rem_reg, quo_reg[NUM_W-1]};
    assign trial_ge = (trial >= {1'b0, span_reg});

    assign quo_ext  = SAT_W'(quo_reg);
    assign rate_sat = (quo_ext > SAT_W'(RATE_MAX)) ? RATE_MAX : RATE_W'(quo_ext);

    assign sts.is_rec   = (op_reg == CMD_RECORD);
    assign sts.ins_zero = (ins_reg == '0);
    assign sts.rd_gt    = (rd_data > t_reg);
    assign sts.pr_old   = ((newest_reg - rd_data) > TIME_W'(window_reg));
    assign sts.div_last = (div_cnt_reg == DCNT_W'(NUM_W - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= WINDOW_RESET;
            gap_reg    <= GAP_RESET;
            head_reg   <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_WINDOW: window_reg <= cfg_data;
                    REG_GAP:    gap_reg    <= cfg_data;
                    default:    window_reg <= window_reg;
                endcase
            end
            if (ctl.pre)
            begin
                if (op_reg == CMD_RECORD)
                begin
                    head_reg  <= evict ? inc_ptr(head_reg) : head_reg;
                    count_reg <= evict ? CNT_W'(MAX_ARRIVALS - 1) : cnt_after_gap;
                end
                else if (op_reg == CMD_CLEAR)
                begin
                    count_reg <= '0;
                end
            end
            if (ctl.ins_put)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            if (ctl.pr_drop)
            begin
                head_reg  <= inc_ptr(head_reg);
                count_reg <= cnt_m1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.latch)
        begin
            op_reg <= item_cmd;
            t_reg  <= item_time;
        end
        if (ctl.pre)
        begin
            dropped_reg <= (op_reg == CMD_RECORD) && evict;
            ins_reg     <= evict ? CNT_W'(MAX_ARRIVALS - 1) : cnt_after_gap;
        end
        if (ctl.ins_move)
        begin
            ins_reg <= ins_reg - CNT_W'(1);
        end
        if (ctl.ins_put)
        begin
            if ((count_reg == '0) || (t_reg >= newest_reg))
            begin
                newest_reg <= t_reg;
            end
        end
        if (ctl.pr_keep)
        begin
            oldest_reg <= rd_data;
        end
        if (ctl.rate_setup)
        begin
            zero_reg    <= rate_zero;
            span_reg    <= newest_reg - oldest_reg;
            quo_reg     <= NUM_W'(cnt_m1) * NUM_W'(USEC_Q8);
            rem_reg     <= '0;
            div_cnt_reg <= '0;
        end
        if (ctl.div_step)
        begin
            rem_reg     <= trial_ge ? TIME_W'(trial - {1'b0, span_reg})
                                    : trial[TIME_W-1:0];
            quo_reg     <= {quo_reg[NUM_W-2:0], trial_ge};
            div_cnt_reg <= div_cnt_reg + DCNT_W'(1);
        end
        if (ctl.load_out)
        begin
            rate_out_reg <= zero_reg ? '0 : rate_sat;
            held_out_reg <= HELD_W'(count_reg);
            drop_out_reg <= dropped_reg;
        end
    end

    assign rate_q8       = rate_out_reg;
    assign arrivals_held = held_out_reg;
    assign dropped_full  = drop_out_reg;

endmodule

// File: sv/sliding_window_packet_rate_meter_core.sv
// Sequence: a query or clear is latched, passes the pre step, the rate setup and the serial
// divider, then loads the output register. A record also runs, after the pre step, an insertion
// scan (check, compare per entry moved) and a prune scan (read, compare per entry pruned).
// Throughput: one item in work at a time; the next is accepted once the controller is idle.
// Reset: rst_n is asynchronous and active low; it empties the window, restores window_us
// and gap_us to their reset values and drops any pending result. Stored times need no clear.
module sliding_window_packet_rate_meter_core #(
    parameter int MAX_ARRIVALS = swprm_pkg::MAX_ARRIVALS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    swprm_in_if.sink                     in_ch,
    swprm_out_if.source                  out_ch,
    input  logic                         cfg_we,
    input  logic [swprm_pkg::IDX_W-1:0]  cfg_index,
    input  logic [swprm_pkg::CFG_W-1:0]  cfg_data
);

    import swprm_pkg::*;

    // The controller sequences each item through its phases: for a
    // record, window reset on a long gap and full-store eviction, an
    // insertion scan that walks from the newest entry downward moving
    // larger times up one slot and a prune scan from the oldest entry;
    // for every item, the rate division. The datapath owns the circular
    // timestamp memory, the window bookkeeping and the divider.
    ctl_cmd_t ctl;
    ctl_sts_t sts;

    swprm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .sts       (sts),
        .ctl       (ctl)
    );

    // The item payload is captured on the transfer; the result fields
    // come straight from the datapath's output register, which holds
    // them until the result transfer completes.
    swprm_dp #(
        .MAX_ARRIVALS (MAX_ARRIVALS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (ctl),
        .sts           (sts),
        .item_cmd      (in_ch.cmd),
        .item_time     (in_ch.time_us),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .rate_q8       (out_ch.rate_q8),
        .arrivals_held (out_ch.arrivals_held),
        .dropped_full  (out_ch.dropped_full)
    );

endmodule

// File: sv/swprm_chk.sv
`include "sliding_window_packet_rate_meter_core_assert.svh"

module swprm_chk #(
    parameter int MAX_ARRIVALS = swprm_pkg::MAX_ARRIVALS_DEF
) (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [swprm_pkg::RATE_W-1:0] rate_q8,
    input logic [swprm_pkg::HELD_W-1:0] arrivals_held,
    input logic                         dropped_full
);

    // A result waiting for its transfer stays offered.
    `SWPRM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)

    // The count never exceeds the store depth.
    `SWPRM_ASSERT(a_held_bound, !out_valid || (int'(arrivals_held) <= MAX_ARRIVALS))

    // With fewer than two times held there is no rate.
    `SWPRM_ASSERT(a_rate_few, !out_valid || (MAX_ARRIVALS > 127) || (arrivals_held > 7'd1) || (rate_q8 == '0))

    // An eviction is always followed by an insert, so the window is not empty.
    `SWPRM_ASSERT(a_drop_held, !out_valid || !dropped_full || (MAX_ARRIVALS > 127) || (arrivals_held != '0))

endmodule

bind sliding_window_packet_rate_meter_core swprm_chk #(
    .MAX_ARRIVALS (MAX_ARRIVALS)
) u_swprm_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .rate_q8       (out_ch.rate_q8),
    .arrivals_held (out_ch.arrivals_held),
    .dropped_full  (out_ch.dropped_full)
);

// File: dv/tb_sliding_window_packet_rate_meter_core.sv
module tb_sliding_window_packet_rate_meter_core;
    import swprm_pkg::*;

    localparam int DEPTH = MAX_ARRIVALS_DEF;
    // Worst case per item: sorted insert and prune over the full store plus the divider.
    localparam int SETTLE_CYCLES = 4 * DEPTH + 64;

    // Expected report for one item.
    typedef struct {
        logic [RATE_W-1:0] rate_q8;
        logic [HELD_W-1:0] held;
        logic              dropped;
    } report_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;

    swprm_in_if  in_ch();
    swprm_out_if out_ch();

    sliding_window_packet_rate_meter_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch.sink),
        .out_ch    (out_ch.source),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Predictor state: the sorted window of arrival times and its settings.
    logic [TIME_W-1:0] win_times[DEPTH];
    int unsigned       win_count;
    logic [CFG_W-1:0]  win_len_us;
    logic [CFG_W-1:0]  gap_len_us;

    report_t pending_reports[$];
    int      error_count;

    // Idling controls: two in percent of cycles, and a receiver hold-off count.
    int send_idle_pct;
    int recv_stall_pct;
    int hold_off_cycles;

    // Reference time that random arrivals advance from.
    logic [TIME_W-1:0] clock_us;

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Removes the n oldest times from the window.
    function automatic void drop_oldest(int unsigned n);
        if (n >= win_count)
        begin
            win_count = 0;
            return;
        end
        for (int unsigned i = 0; i + n < win_count; i++)
            win_times[i] = win_times[i + n];
        win_count -= n;
    endfunction

    // Records one arrival; returns 1 when the full store forced an eviction.
    function automatic logic insert_arrival(logic [TIME_W-1:0] t);
        logic evicted;
        int unsigned pos;
        int unsigned old;
        logic [TIME_W-1:0] newest;
        evicted = 1'b0;
        if (win_count > 0)
        begin
            newest = win_times[win_count - 1];
            if (t >= newest && (t - newest) >= gap_len_us)
                win_count = 0;
        end
        if (win_count >= DEPTH)
        begin
            drop_oldest(1);
            evicted = 1'b1;
        end
        pos = 0;
        while (pos < win_count && win_times[pos] <= t)
            pos++;
        for (int unsigned i = win_count; i > pos; i--)
            win_times[i] = win_times[i - 1];
        win_times[pos] = t;
        win_count++;
        newest = win_times[win_count - 1];
        old = 0;
        while (old < win_count && (newest - win_times[old]) > win_len_us)
            old++;
        drop_oldest(old);
        return evicted;
    endfunction

    // Packet rate in Q.8 at the given time, saturating.
    function automatic logic [RATE_W-1:0] rate_now(logic [TIME_W-1:0] now);
        logic [TIME_W-1:0] newest;
        logic [TIME_W-1:0] span;
        logic [63:0] quot;
        if (win_count < 2)
            return '0;
        newest = win_times[win_count - 1];
        if (now < newest || (now - newest) >= gap_len_us)
            return '0;
        span = newest - win_times[0];
        if (span == 0)
            return '0;
        quot = (64'(win_count - 1) * 64'(USEC_Q8)) / 64'(span);
        return (quot > 64'(RATE_MAX)) ? RATE_MAX : quot[RATE_W-1:0];
    endfunction

    function automatic report_t predict_report(logic [CMD_W-1:0] cmd, logic [TIME_W-1:0] t);
        report_t r;
        r.dropped = 1'b0;
        if (cmd == CMD_RECORD)
            r.dropped = insert_arrival(t);
        else if (cmd == CMD_CLEAR)
            win_count = 0;
        r.rate_q8 = rate_now(t);
        r.held = win_count[HELD_W-1:0];
        return r;
    endfunction

    // Offers one item, waits for its transfer and queues the expected report.
    // Valid stays up after the transfer until the next item or an idle cycle.
    task automatic send_item(logic [CMD_W-1:0] cmd, logic [TIME_W-1:0] t);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.cmd     <= cmd;
        in_ch.time_us <= t;
        do
            @(posedge clk);
        while (!in_ch.ready);
        pending_reports.push_back(predict_report(cmd, t));
    endtask

    // Writes a register; only called while nothing is in flight.
    task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_WINDOW)
            win_len_us = value;
        else
            gap_len_us = value;
    endtask

    // Lets every expected report arrive, then allows the block to go idle.
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic set_window(logic [CFG_W-1:0] win, logic [CFG_W-1:0] gap);
        drain();
        write_reg(REG_WINDOW, win);
        write_reg(REG_GAP, gap);
    endtask

    // Counts down a requested long hold-off of the receiver.
    always @(posedge clk)
    begin
        if (hold_off_cycles > 0)
            hold_off_cycles <= hold_off_cycles - 1;
    end

    // Receiver side: stalls at random, or holds off while a hold-off is counting.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else if (hold_off_cycles > 0)
            out_ch.ready <= 1'b0;
        else
            out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Compares every report transfer with the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pending_reports.size() == 0)
            begin
                $error("report with no expectation waiting");
                error_count++;
            end
            else
            begin
                report_t exp_r;
                exp_r = pending_reports[0];
                pending_reports.delete(0);
                if (out_ch.rate_q8 !== exp_r.rate_q8)
                begin
                    $error("rate_q8: expected %0d, actual %0d", exp_r.rate_q8, out_ch.rate_q8);
                    error_count++;
                end
                if (out_ch.arrivals_held !== exp_r.held)
                begin
                    $error("arrivals_held: expected %0d, actual %0d",
                           exp_r.held, out_ch.arrivals_held);
                    error_count++;
                end
                if (out_ch.dropped_full !== exp_r.dropped)
                begin
                    $error("dropped_full: expected %0d, actual %0d",
                           exp_r.dropped, out_ch.dropped_full);
                    error_count++;
                end
            end
        end
    end

    // Random time near the current clock: mostly forward steps, some out of order.
    function automatic logic [TIME_W-1:0] next_time(int unsigned max_step);
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 80)
            clock_us = clock_us + $urandom_range(max_step);
        else if (pick < 95)
            return clock_us - $urandom_range(max_step);
        else
            clock_us = clock_us + gap_len_us + $urandom_range(3);
        return clock_us;
    endfunction

    // Extremes of every field, each command and the special cases named for the block.
    task automatic test_directed();
        send_item(CMD_QUERY, '0);
        send_item(CMD_RECORD, '0);
        send_item(CMD_RECORD, '0);              // newest equals oldest: zero span
        send_item(CMD_RECORD, 48'd1);           // tiny span gives a large rate
        send_item(CMD_QUERY, 48'd1);
        send_item(CMD_QUERY, '0);               // query before the newest entry
        send_item(CMD_RECORD, 48'd500);
        send_item(CMD_RECORD, 48'd200);         // older arrival inserted in place
        send_item(CMD_QUERY, 48'd2000499);      // just short of the gap
        send_item(CMD_QUERY, 48'd2000500);      // exactly one gap old
        send_item(CMD_RECORD, 48'd1500000);     // prunes older entries
        send_item(CMD_RECORD, 48'd4000000);     // gap empties the window first
        send_item(CMD_SPARE, 48'd4000000);      // unused command acts as a query
        send_item(CMD_CLEAR, 48'd4000001);
        send_item(CMD_RECORD, {TIME_W{1'b1}});
        send_item(CMD_RECORD, {TIME_W{1'b1}} - 48'd1);
        send_item(CMD_QUERY, {TIME_W{1'b1}});
        send_item(CMD_QUERY, 48'h555555555555);
        send_item(CMD_CLEAR, 48'hAAAAAAAAAAAA);
    endtask

    // Fills the store past its depth so the oldest entry is evicted.
    task automatic test_full_store();
        clock_us = 48'd1000;
        for (int i = 0; i < DEPTH + 6; i++)
        begin
            clock_us = clock_us + $urandom_range(1, 3);
            send_item(CMD_RECORD, clock_us);
        end
        send_item(CMD_QUERY, clock_us);
        send_item(CMD_CLEAR, clock_us);
    endtask

    // Zero window keeps only ties with the newest; zero gap empties on every arrival not older than the newest.
    task automatic test_zero_settings();
        set_window('0, 24'd50);
        send_item(CMD_RECORD, 48'd10);
        send_item(CMD_RECORD, 48'd10);
        send_item(CMD_RECORD, 48'd11);
        send_item(CMD_QUERY, 48'd11);
        set_window(24'd100, '0);
        send_item(CMD_RECORD, 48'd20);
        send_item(CMD_RECORD, 48'd19);
        send_item(CMD_QUERY, 48'd20);
        send_item(CMD_RECORD, 48'd21);
        set_window({CFG_W{1'b1}}, {CFG_W{1'b1}});
        send_item(CMD_RECORD, 48'd30);
        send_item(CMD_RECORD, 48'd30 + 48'hFFFFFF);
        send_item(CMD_QUERY, 48'd30 + 48'h1FFFFFD);
    endtask

    // Random traffic: mostly arrivals in rough time order, with queries, clears and noise.
    task automatic test_random(int n, int unsigned max_step);
        int unsigned pick;
        logic [TIME_W-1:0] t;
        for (int i = 0; i < n; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 2)
                t = {$urandom, $urandom} & {TIME_W{1'b1}};
            else
                t = next_time(max_step);
            if (pick < 60)
                send_item(CMD_RECORD, t);
            else if (pick < 92)
                send_item(CMD_QUERY, t);
            else if (pick < 96)
                send_item(CMD_SPARE, t);
            else
                send_item(CMD_CLEAR, t);
        end
    endtask

    // Receiver holds off long enough for the block to stall its input.
    task automatic test_back_pressure();
        hold_off_cycles <= 2000;
        test_random(12, 40);
    endtask

    initial
    begin
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        in_ch.valid     = 1'b0;
        in_ch.cmd       = '0;
        in_ch.time_us   = '0;
        error_count     = 0;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        hold_off_cycles = 0;
        win_count       = 0;
        win_len_us      = WINDOW_RESET;
        gap_len_us      = GAP_RESET;
        clock_us        = '0;
        repeat (3)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_full_store();
        test_zero_settings();

        // Small window, no idling.
        set_window(24'd300, 24'd400);
        clock_us = 48'd5000;
        test_random(120, 60);

        // Sender idle about half the time.
        send_idle_pct = 52;
        set_window(24'd1, 24'd8);
        test_random(80, 4);

        // Receiver stalling about half the time.
        send_idle_pct  = 0;
        recv_stall_pct = 52;
        set_window(24'd5000, 24'd20000);
        test_random(120, 400);

        // Both sides idle now and then.
        send_idle_pct  = 12;
        recv_stall_pct = 12;
        set_window(WINDOW_RESET, GAP_RESET);
        test_random(120, 200000);

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        test_back_pressure();

        drain();
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        #30000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
